>>> rtl/core/dvps_pkg.sv
// package: shared types, constants and arithmetic helpers for the particle step block
`timescale 1ns / 1ps
package dvps_pkg;

	localparam int SLOT_W = 10;
	localparam int POS_W  = 32;
	localparam int MASS_W = 16;
	localparam int TIME_W = 32;
	localparam int DAMP_W = 16;

	// hardware quotient width: push (32) shifted left by 8
	localparam int DIV_N_W = 40;

	// push divider depth, set equal to the quotient width
	localparam int DIV_STAGES = DIV_N_W;

	typedef enum logic [0:0] {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_DAMPING      = 2'd0,
		REG_STEP_SQUARED = 2'd1,
		REG_GRAVITY      = 2'd2
	} reg_idx_t;

	// one particle record as held in the table memory
	typedef struct packed {
		logic signed [POS_W-1:0]  cx;
		logic signed [POS_W-1:0]  cy;
		logic signed [POS_W-1:0]  cz;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  pz;
		logic signed [POS_W-1:0]  push;
		logic [MASS_W-1:0]        mass;
		logic [TIME_W-1:0]        age;
		logic [TIME_W-1:0]        life;
		logic                     still;
		logic                     live;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic [DAMP_W-1:0]        damping;
		logic [TIME_W-1:0]        step_sq;
		logic signed [POS_W-1:0]  gravity;
	} cfg_t;

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [79:0] v);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		begin
			hi = 80'sd2147483647;
			lo = -80'sd2147483648;
			if (v > hi) sat32 = 32'h7fff_ffff;
			else if (v < lo) sat32 = 32'h8000_0000;
			else sat32 = v[POS_W-1:0];
		end
	endfunction

endpackage

>>> rtl/core/dvps_if.sv
// valid/ready channel interfaces for the particle step block
`timescale 1ns / 1ps
interface dvps_in_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [dvps_pkg::SLOT_W-1:0]     slot;
	logic signed [31:0]              start_x;
	logic signed [31:0]              start_y;
	logic signed [31:0]              start_z;
	logic [15:0]                     spawn_mass;
	logic [31:0]                     spawn_life;
	logic                            spawn_still;
	logic [31:0]                     delta_time;
	modport source (output valid, kind, slot, start_x, start_y, start_z, spawn_mass,
		spawn_life, spawn_still, delta_time, input ready);
	modport sink (input valid, kind, slot, start_x, start_y, start_z, spawn_mass,
		spawn_life, spawn_still, delta_time, output ready);
endinterface

interface dvps_out_if;
	logic                            valid;
	logic                            ready;
	logic [dvps_pkg::SLOT_W-1:0]     out_slot;
	logic signed [31:0]              pos_x;
	logic signed [31:0]              pos_y;
	logic signed [31:0]              pos_z;
	logic                            alive;
	logic [31:0]                     age_now;
	modport source (output valid, out_slot, pos_x, pos_y, pos_z, alive, age_now,
		input ready);
	modport sink (input valid, out_slot, pos_x, pos_y, pos_z, alive, age_now,
		output ready);
endinterface

>>> rtl/core/damped_verlet_particle_step.sv
// top level: particle table, read-modify-write pipeline and result register
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | kind slot start_xyz spawn_mass spawn_life spawn_still delta_time
//  out_ch   | out | valid/ready   | out_slot pos_xyz alive age_now
//  cfg      | in  | cfg_we        | cfg_index cfg_data
//
// one item per cycle when not stalled or held; each item passes table read, age stage,
// the 40-stage push divider and three verlet stages, then the output register
// the whole pipeline stalls while the output register holds an untaken item
// an item on an entry still in flight waits until that entry's write-back is done
// after reset a clearing pass writes every entry, input not ready meanwhile
`timescale 1ns / 1ps
module damped_verlet_particle_step #(
	parameter int NUM_PARTICLES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	dvps_in_if.sink          in_ch,
	dvps_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	localparam int IW = $clog2(NUM_PARTICLES);
	localparam int NS = dvps_pkg::DIV_STAGES + 5;

	typedef struct packed {
		logic                         kind;
		logic [dvps_pkg::SLOT_W-1:0]  slot;
		logic                         in_range;
		logic signed [31:0]           sx;
		logic signed [31:0]           sy;
		logic signed [31:0]           sz;
		logic [15:0]                  mass;
		logic [31:0]                  life;
		logic                         still;
		logic [31:0]                  dt;
	} op_t;

	dvps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.damping <= 16'd655;
			cfg_q.step_sq <= 32'd1193046;
			cfg_q.gravity <= -32'sd642908;
		end else if (cfg_we) begin
			case (dvps_pkg::reg_idx_t'(cfg_index))
				dvps_pkg::REG_DAMPING:      cfg_q.damping <= cfg_data[15:0];
				dvps_pkg::REG_STEP_SQUARED: cfg_q.step_sq <= cfg_data;
				dvps_pkg::REG_GRAVITY:      cfg_q.gravity <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance enable
	logic adv;
	logic obuf_full_q;
	assign adv = !obuf_full_q || out_ch.ready;

	// in-flight tracking by valid bits of each stage
	logic          v   [NS+1];
	logic [IW-1:0] ix  [NS+1];
	logic          wr  [NS+1];

	// table clearing pass after reset
	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IW'(NUM_PARTICLES - 1)) clr_busy_q <= 1'b0;
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	logic hazard;
	logic [IW-1:0] in_idx;
	logic in_rng;
	assign in_rng = (NUM_PARTICLES > 1024) || ({22'd0, in_ch.slot} < 32'(NUM_PARTICLES));
	assign in_idx = IW'(in_ch.slot);

	always_comb begin
		hazard = 1'b0;
		for (int k = 1; k <= NS; k++) begin
			if (v[k] && wr[k] && ix[k] == in_idx) hazard = 1'b1;
		end
	end

	logic take;
	assign in_ch.ready = adv && !hazard && !clr_busy_q;
	assign take = in_ch.valid && in_ch.ready;

	// stage 1: memory read issued, op captured
	op_t op_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1.kind     <= in_ch.kind;
			op_s1.slot     <= in_ch.slot;
			op_s1.in_range <= in_rng;
			op_s1.sx       <= in_ch.start_x;
			op_s1.sy       <= in_ch.start_y;
			op_s1.sz       <= in_ch.start_z;
			op_s1.mass     <= (in_ch.spawn_mass == '0) ? 16'd1 : in_ch.spawn_mass;
			op_s1.life     <= in_ch.spawn_life;
			op_s1.still    <= in_ch.spawn_still;
			op_s1.dt       <= in_ch.delta_time;
		end
	end

	always_comb begin
		v[0]  = take;
		ix[0] = in_idx;
		wr[0] = in_rng;
	end

	for (genvar k = 0; k < NS; k++) begin : g_trk
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v[k+1] <= 1'b0;
			else if (adv) v[k+1] <= v[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ix[k+1] <= ix[k];
				wr[k+1] <= wr[k];
			end
		end
	end

	dvps_pkg::rec_t rd_rec;
	dvps_pkg::rec_t wb_rec;
	logic           wb_we;
	logic [IW-1:0]  wb_idx;

	logic                       ram_we;
	logic [IW-1:0]              ram_waddr;
	logic [dvps_pkg::REC_W-1:0] ram_wdata;
	assign ram_we    = wb_we || clr_busy_q;
	assign ram_waddr = clr_busy_q ? clr_idx_q : wb_idx;
	assign ram_wdata = clr_busy_q ? dvps_pkg::REC_W'(0) : wb_rec;

	dvps_ram #(.WIDTH(dvps_pkg::REC_W), .DEPTH(NUM_PARTICLES)) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv),
		.raddr(in_idx),
		.rdata(rd_rec)
	);

	// stage 2: age update, decide branch, launch divide
	op_t            op_s2;
	dvps_pkg::rec_t rec_s2;
	logic [31:0]    age_s2;
	logic           retire_s2;
	logic [32:0] age_sum;
	assign age_sum = {1'b0, rd_rec.age} + {1'b0, op_s1.dt};

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2     <= op_s1;
			rec_s2    <= rd_rec;
			age_s2    <= age_sum[32] ? 32'hffff_ffff : age_sum[31:0];
			retire_s2 <= (age_sum[32] ? 32'hffff_ffff : age_sum[31:0]) > rd_rec.life;
		end
	end

	typedef struct packed {
		op_t            op;
		dvps_pkg::rec_t rec;
		logic [31:0]    age;
		logic           retire;
	} carry_t;

	carry_t         c_in;
	carry_t         c_out;
	logic signed [39:0] quo;
	assign c_in = '{op: op_s2, rec: rec_s2, age: age_s2, retire: retire_s2};

	dvps_div #(.NW(40), .DW(16), .TW($bits(carry_t))) u_div (
		.clk    (clk),
		.en     (adv),
		.num    ({rec_s2.push, 8'd0}),
		.den    (rec_s2.mass),
		.tag_in (c_in),
		.quo    (quo),
		.tag_out(c_out)
	);

	// stage 3: saturate accel, start products
	carry_t c_s3;
	logic signed [31:0] acc_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3   <= c_out;
			acc_s3 <= dvps_pkg::sat32(80'(quo));
		end
	end

	// stage 4: products of positions and accel term, gravity times mass
	carry_t c_s4;
	logic signed [50:0] pxa_s4, pya_s4, pza_s4, oxa_s4, oya_s4, oza_s4;
	logic signed [64:0] trm_s4;
	logic signed [48:0] gm_s4;
	logic signed [18:0] ka, kb;
	assign ka = 19'sd131072 - $signed({3'b0, cfg_q.damping});
	assign kb = 19'sd65536 - $signed({3'b0, cfg_q.damping});
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4   <= c_s3;
			pxa_s4 <= c_s3.rec.cx * ka;
			pya_s4 <= c_s3.rec.cy * ka;
			pza_s4 <= c_s3.rec.cz * ka;
			oxa_s4 <= c_s3.rec.px * kb;
			oya_s4 <= c_s3.rec.py * kb;
			oza_s4 <= c_s3.rec.pz * kb;
			trm_s4 <= acc_s3 * $signed({1'b0, cfg_q.step_sq});
			gm_s4  <= cfg_q.gravity * $signed({1'b0, c_s3.rec.mass});
		end
	end

	// stage 5: sums and saturation
	carry_t c_s5;
	logic signed [31:0] nx_s5, ny_s5, nz_s5, np_s5;
	logic signed [52:0] sx, sy, sz;
	assign sx = 53'(pxa_s4) - 53'(oxa_s4);
	assign sz = 53'(pza_s4) - 53'(oza_s4);
	assign sy = 53'(pya_s4) - 53'(oya_s4) + 53'(trm_s4 >>> 16);
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5  <= c_s4;
			nx_s5 <= dvps_pkg::sat32(80'(sx >>> 16));
			ny_s5 <= dvps_pkg::sat32(80'(sy >>> 16));
			nz_s5 <= dvps_pkg::sat32(80'(sz >>> 16));
			np_s5 <= dvps_pkg::sat32(80'(gm_s4 >>> 8));
		end
	end

	// write-back and result forming
	op_t o5;
	assign o5 = c_s5.op;
	logic       is_load, moving, st_live;
	assign is_load = o5.kind == dvps_pkg::KIND_LOAD;
	assign st_live = c_s5.rec.live && !c_s5.retire;
	assign moving  = !is_load && st_live && !c_s5.rec.still;

	// the load path needs no tail stage, yet keeps order by riding the same pipe
	logic fire;
	assign fire = v[NS] && adv;

	always_comb begin
		wb_rec = c_s5.rec;
		wb_idx = IW'(o5.slot);
		wb_we  = fire && o5.in_range && (is_load || c_s5.rec.live);
		if (is_load) begin
			wb_rec.cx = o5.sx; wb_rec.px = o5.sx;
			wb_rec.cy = o5.sy; wb_rec.py = o5.sy;
			wb_rec.cz = o5.sz; wb_rec.pz = o5.sz;
			wb_rec.push = '0;
			wb_rec.mass = o5.mass;
			wb_rec.age = '0;
			wb_rec.life = o5.life;
			wb_rec.still = o5.still;
			wb_rec.live = 1'b1;
		end else begin
			wb_rec.age = c_s5.age;
			if (c_s5.retire) wb_rec.live = 1'b0;
			if (st_live && c_s5.rec.still) wb_rec.push = '0;
			if (moving) begin
				wb_rec.px = c_s5.rec.cx; wb_rec.cx = nx_s5;
				wb_rec.py = c_s5.rec.cy; wb_rec.cy = ny_s5;
				wb_rec.pz = c_s5.rec.cz; wb_rec.cz = nz_s5;
				wb_rec.push = np_s5;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) obuf_full_q <= 1'b0;
		else if (adv) obuf_full_q <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_ch.out_slot <= o5.slot;
			if (!o5.in_range || (!is_load && !c_s5.rec.live)) begin
				out_ch.pos_x <= '0; out_ch.pos_y <= '0; out_ch.pos_z <= '0;
				out_ch.alive <= 1'b0; out_ch.age_now <= '0;
			end else begin
				out_ch.pos_x   <= wb_rec.cx;
				out_ch.pos_y   <= wb_rec.cy;
				out_ch.pos_z   <= wb_rec.cz;
				out_ch.alive   <= is_load || st_live;
				out_ch.age_now <= wb_rec.age;
			end
		end
	end

	assign out_ch.valid = obuf_full_q;
endmodule

>>> rtl/core/dvps_ram.sv
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps
module dvps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/dvps_div.sv
// pipelined signed divider: one quotient bit per stage, truncating toward zero
`timescale 1ns / 1ps
module dvps_div #(
	parameter int NW  = 40,
	parameter int DW  = 16,
	parameter int TW  = 8
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]       den,
	input  logic [TW-1:0]       tag_in,
	output logic signed [NW-1:0] quo,
	output logic [TW-1:0]       tag_out
);
	logic [NW-1:0]  q_r   [NW+1];
	logic [DW:0]    r_r   [NW+1];
	logic [DW-1:0]  d_r   [NW+1];
	logic           neg_r [NW+1];
	logic [TW-1:0]  t_r   [NW+1];

	always_comb begin
		q_r[0]   = num[NW-1] ? NW'(-num) : NW'(num);
		r_r[0]   = '0;
		d_r[0]   = den;
		neg_r[0] = num[NW-1];
		t_r[0]   = tag_in;
	end

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW+1:0] trial;
		logic [DW+1:0] shifted;
		assign shifted = {r_r[i], q_r[i][NW-1]};
		assign trial   = shifted - {2'b00, d_r[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[DW+1]) begin
					r_r[i+1] <= trial[DW:0];
					q_r[i+1] <= {q_r[i][NW-2:0], 1'b1};
				end else begin
					r_r[i+1] <= shifted[DW:0];
					q_r[i+1] <= {q_r[i][NW-2:0], 1'b0};
				end
				d_r[i+1]   <= d_r[i];
				neg_r[i+1] <= neg_r[i];
				t_r[i+1]   <= t_r[i];
			end
		end
	end

	assign quo     = neg_r[NW] ? -$signed(q_r[NW]) : $signed(q_r[NW]);
	assign tag_out = t_r[NW];
endmodule

>>> rtl/core/dvps_checker.sv
// port-level checker for the particle step block, bound to the top level
`timescale 1ns / 1ps
module dvps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_alive,
	input logic [31:0] out_age_now
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out item dropped");
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");
	a_dead_age: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_alive |-> out_age_now != 32'hffff_ffff || out_alive)
		else $error("age check");
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid) else $error("out valid in reset");
endmodule

bind damped_verlet_particle_step dvps_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_alive  (out_ch.alive),
	.out_age_now(out_ch.age_now)
);
